FILE: rtl/glmd_pkg.sv
package glmd_pkg;

  localparam int VALUE_BITS      = 4;
  localparam int COORD_BITS      = 7;
  localparam int RISK_BITS       = 18;
  localparam int CFG_BITS        = 8;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int DEF_MAX_WIDTH   = 128;
  localparam int DEF_MAX_HEIGHT  = 128;
  localparam int IMAGE_DIM_RESET = 100;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

  typedef struct packed {
    logic [VALUE_BITS-1:0] cell_height;
    logic                  pad;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] cell_row;
    logic [COORD_BITS-1:0] cell_col;
    logic [VALUE_BITS-1:0] cell_value;
    logic                  is_minimum;
    logic [RISK_BITS-1:0]  risk_total;
    logic                  frame_last;
  } out_item_t;

endpackage

FILE: rtl/grid_local_minimum_detector_core.sv
// result: a cell's result is registered on the transfer of the cell directly below it
//   (one row later); pad row items decide the last real row
// throughput: one input transfer per cycle while no result is stalled (a single chain shift)
// reset: counters, risk sum and output valid cleared; both dimensions return to 100
//   (clamped to the maximum); the line cells hold stale data until refilled
module grid_local_minimum_detector_core import glmd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_item_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_item_t                 out_data,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data
);

  localparam int CB      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int HB      = $clog2(MAX_HEIGHT + 1);
  localparam int RESET_W = (IMAGE_DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : IMAGE_DIM_RESET;
  localparam int RESET_H = (IMAGE_DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : IMAGE_DIM_RESET;

  // clamped dimensions: last column index and row count
  logic [CB-1:0] width_last;
  logic [HB-1:0] height;
  logic [CB-1:0] cfg_w_last;
  logic [HB-1:0] cfg_h;

  // stream position of the next item and the frame's risk sum
  logic [CB-1:0]        col;
  logic [HB-1:0]        row;
  logic [RISK_BITS-1:0] risk;

  // neighborhood taps
  logic [VALUE_BITS-1:0] prev_head;   // row above, same column: the cell being decided
  logic [VALUE_BITS-1:0] prev_right;  // its right neighbor
  logic [VALUE_BITS-1:0] up_head;     // two rows above: its upper neighbor
  logic [VALUE_BITS-1:0] up_right;
  logic [VALUE_BITS-1:0] left;        // the cell decided one transfer earlier

  logic                 take;
  logic                 decide;
  logic                 at_col_end;
  logic                 at_pad_row;
  logic                 is_min;
  logic [RISK_BITS:0]   risk_sum;
  logic [RISK_BITS-1:0] risk_next;
  logic                 restart;

  // output register parts the two sides; input stalls only when it holds a stalled result
  assign in_stall = out_valid && out_stall;
  assign take     = in_valid && !in_stall;

  assign at_col_end = (col == width_last);
  assign at_pad_row = (row == height);
  assign decide     = (row != '0);

  // clamp of a written dimension to 2..max
  always_comb begin
    if (cfg_data < CFG_BITS'(2)) begin
      cfg_w_last = CB'(1);
      cfg_h      = HB'(2);
    end else begin
      if (32'(cfg_data) > MAX_WIDTH) begin
        cfg_w_last = CB'(MAX_WIDTH - 1);
      end else begin
        cfg_w_last = CB'(cfg_data - CFG_BITS'(1));
      end
      if (32'(cfg_data) > MAX_HEIGHT) begin
        cfg_h = HB'(MAX_HEIGHT);
      end else begin
        cfg_h = HB'(cfg_data);
      end
    end
  end

  // line of the row above fed by the stream, line two rows above fed by its head
  glmd_line #(.DEPTH(MAX_WIDTH)) u_prev_line (
    .clk       (clk),
    .shift     (take),
    .tail      (width_last),
    .din       (in_data.cell_height),
    .head      (prev_head),
    .head_next (prev_right)
  );

  glmd_line #(.DEPTH(MAX_WIDTH)) u_up_line (
    .clk       (clk),
    .shift     (take),
    .tail      (width_last),
    .din       (prev_head),
    .head      (up_head),
    .head_next (up_right)
  );

  always_ff @(posedge clk) begin
    if (take) begin
      left <= prev_head;
    end
  end

  // strict compare against every neighbor that exists
  always_comb begin
    is_min = 1'b1;
    if (col != '0 && left <= prev_head) begin
      is_min = 1'b0;
    end
    if (!at_col_end && prev_right <= prev_head) begin
      is_min = 1'b0;
    end
    if (row >= HB'(2) && up_head <= prev_head) begin
      is_min = 1'b0;
    end
    if (!at_pad_row && in_data.cell_height <= prev_head) begin
      is_min = 1'b0;
    end
  end

  // running risk, saturating at the field's maximum
  always_comb begin
    risk_sum = {1'b0, risk} + (RISK_BITS+1)'(prev_head) + (RISK_BITS+1)'(1);
    if (is_min) begin
      risk_next = risk_sum[RISK_BITS] ? '1 : risk_sum[RISK_BITS-1:0];
    end else begin
      risk_next = risk;
    end
  end

  assign restart = cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_last <= CB'(RESET_W - 1);
      height     <= HB'(RESET_H);
      col        <= '0;
      row        <= '0;
      risk       <= '0;
    end else if (restart) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        width_last <= cfg_w_last;
      end else begin
        height <= cfg_h;
      end
      col  <= '0;
      row  <= '0;
      risk <= '0;
    end else if (take) begin
      if (at_col_end && at_pad_row) begin
        // frame done: next frame starts clean
        col  <= '0;
        row  <= '0;
        risk <= '0;
      end else begin
        if (decide) begin
          risk <= risk_next;
        end
        if (at_col_end) begin
          col <= '0;
          row <= row + HB'(1);
        end else begin
          col <= col + CB'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && decide) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && decide) begin
      out_data.cell_row   <= COORD_BITS'(row - HB'(1));
      out_data.cell_col   <= COORD_BITS'(col);
      out_data.cell_value <= prev_head;
      out_data.is_minimum <= is_min;
      out_data.risk_total <= risk_next;
      out_data.frame_last <= at_col_end && at_pad_row;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty result register");

  a_decide_gives_result: assert property (@(posedge clk) disable iff (rst)
    (take && decide) |=> out_valid)
    else $error("decided cell did not reach the result register");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (col <= width_last) && (row <= height))
    else $error("stream position beyond frame");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (take && !cfg_we && at_col_end && at_pad_row) |=> (row == '0 && col == '0 && risk == '0))
    else $error("frame end did not restart counters");

  a_first_row_silent: assert property (@(posedge clk) disable iff (rst)
    (take && !decide && !(out_valid && !out_stall) && !out_valid) |=> !out_valid)
    else $error("first row produced a result");
`endif

endmodule

FILE: rtl/glmd_cell.sv
module glmd_cell import glmd_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic                  load,
  input  logic [VALUE_BITS-1:0] din_tail,
  input  logic [VALUE_BITS-1:0] din_next,
  output logic [VALUE_BITS-1:0] q
);

  // a cell takes the new value when it is the tail, else its neighbor's
  always_ff @(posedge clk) begin
    if (en) begin
      q <= load ? din_tail : din_next;
    end
  end

endmodule

FILE: rtl/glmd_line.sv
module glmd_line import glmd_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH,
  localparam int IW   = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  shift,
  input  logic [IW-1:0]         tail,
  input  logic [VALUE_BITS-1:0] din,
  output logic [VALUE_BITS-1:0] head,
  output logic [VALUE_BITS-1:0] head_next
);

  logic [VALUE_BITS-1:0] q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_BITS-1:0] nb;
    if (i == DEPTH - 1) begin : g_end
      assign nb = din;
    end else begin : g_mid
      assign nb = q[i+1];
    end
    glmd_cell u_cell (
      .clk      (clk),
      .en       (shift),
      .load     (tail == IW'(i)),
      .din_tail (din),
      .din_next (nb),
      .q        (q[i])
    );
  end

  assign head      = q[0];
  assign head_next = q[1];

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import glmd_pkg::*;

  localparam int RISK_CAP = (1 << RISK_BITS) - 1;

  // one line of the directed script: either a register write or a cell transfer,
  // optionally with the decision typed in by hand
  typedef struct {
    bit                        is_cfg;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [CFG_BITS-1:0]       val;
    in_item_t                  pixel;
    bit                        typed;
    out_item_t                 want;
  } script_row_t;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  in_item_t                  in_data   = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  out_item_t                 out_data;
  logic                      cfg_we    = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]       cfg_data  = '0;

  grid_local_minimum_detector_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // shadow of the raster scan: two line rows picked by row parity, scan position,
  // running risk of the frame and the raw register contents
  logic [VALUE_BITS-1:0] line_rows [2][DEF_MAX_WIDTH];
  int                    scan_col;
  int                    scan_row;
  int                    frame_risk;
  logic [CFG_BITS-1:0]   width_reg  = CFG_BITS'(IMAGE_DIM_RESET);
  logic [CFG_BITS-1:0]   height_reg = CFG_BITS'(IMAGE_DIM_RESET);

  out_item_t decisions_due[$];
  int        error_count       = 0;
  int        cells_sent        = 0;
  int        decisions_checked = 0;
  int        minima_seen       = 0;
  int        settings_used     = 0;
  bit        gapless           = 1'b0;

  function automatic int clamp_dim(input int raw, input int top);
    if (raw < 2) return 2;
    if (raw > top) return top;
    return raw;
  endfunction

  // advance the scan by one cell; returns 1 with the decision of the cell one row up
  function automatic bit decide_cell(input in_item_t it, output out_item_t res);
    int w, h, col, row, cur, prv, center;
    bit low;
    w = clamp_dim(int'(width_reg), DEF_MAX_WIDTH);
    h = clamp_dim(int'(height_reg), DEF_MAX_HEIGHT);
    col = scan_col;
    row = scan_row;
    if (col >= w) col = w - 1;
    if (row > h) row = h;
    cur = row % 2;
    prv = 1 - cur;
    res = '0;
    decide_cell = 1'b0;
    if (row >= 1) begin
      center = int'(line_rows[prv][col]);
      low = 1'b1;
      // strict compare against every neighbor that lies inside the image
      if (col > 0 && int'(line_rows[prv][col-1]) <= center) low = 1'b0;
      if (col + 1 < w && int'(line_rows[prv][col+1]) <= center) low = 1'b0;
      if (row >= 2 && int'(line_rows[cur][col]) <= center) low = 1'b0;
      // in the pad row the incoming value is no neighbor
      if (row < h && int'(it.cell_height) <= center) low = 1'b0;
      if (low) begin
        frame_risk += 1 + center;
        if (frame_risk > RISK_CAP) frame_risk = RISK_CAP;
      end
      res.cell_row   = COORD_BITS'(row - 1);
      res.cell_col   = COORD_BITS'(col);
      res.cell_value = VALUE_BITS'(center);
      res.is_minimum = low;
      res.risk_total = RISK_BITS'(frame_risk);
      res.frame_last = (row == h) && (col == w - 1);
      decide_cell = 1'b1;
    end
    if (row < h) line_rows[cur][col] = it.cell_height;
    col++;
    if (col >= w) begin
      col = 0;
      row++;
    end
    // pad row done: next frame starts from scratch
    if (row > h) begin
      scan_col = 0;
      scan_row = 0;
      frame_risk = 0;
    end else begin
      scan_col = col;
      scan_row = row;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gapless || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // 0: full range, 1: crowded low values (many ties), 2: only the extremes
  function automatic logic [VALUE_BITS-1:0] pick_height(input int style);
    case (style)
      0:       return VALUE_BITS'($urandom_range(0, 15));
      1:       return VALUE_BITS'($urandom_range(0, 2));
      default: return VALUE_BITS'($urandom_range(0, 1) * 15);
    endcase
  endfunction

  function automatic script_row_t mk_cfg(input logic [CFG_INDEX_BITS-1:0] idx,
                                         input logic [CFG_BITS-1:0] val);
    script_row_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.val = val;
    return s;
  endfunction

  function automatic script_row_t mk_cell(input int hgt, input bit pad);
    script_row_t s;
    s = '{default: '0};
    s.pixel.cell_height = VALUE_BITS'(hgt);
    s.pixel.pad = pad;
    return s;
  endfunction

  function automatic script_row_t mk_expect(input int hgt, input bit pad, input int r,
                                            input int c, input int v, input bit m,
                                            input int risk, input bit last);
    script_row_t s;
    s = mk_cell(hgt, pad);
    s.typed = 1'b1;
    s.want.cell_row   = COORD_BITS'(r);
    s.want.cell_col   = COORD_BITS'(c);
    s.want.cell_value = VALUE_BITS'(v);
    s.want.is_minimum = m;
    s.want.risk_total = RISK_BITS'(risk);
    s.want.frame_last = last;
    return s;
  endfunction

  // register write; the frame restarts at the write edge
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) width_reg = val;
    else if (idx == REG_IMAGE_HEIGHT) height_reg = val;
    scan_col = 0;
    scan_row = 0;
    frame_risk = 0;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid, wait for every pending decision, then let the pipe go quiet
  task automatic settle_block(input int tail);
    in_valid <= 1'b0;
    do @(posedge clk); while (decisions_due.size() != 0);
    repeat (tail) @(posedge clk);
  endtask

  // offer one cell, hold it until the transfer, then log what it decides
  task automatic offer_cell(input in_item_t it, input bit typed, input out_item_t want);
    int gap;
    bit made;
    out_item_t got;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    // inputs only move at rising edges, so the handshake is stable at the falling one
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    made = decide_cell(it, got);
    if (typed) decisions_due = {decisions_due, want};
    else if (made) decisions_due = {decisions_due, got};
    cells_sent++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // result side: count a transfer at the falling edge before the edge that takes it
  always @(negedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (decisions_due.size() == 0) begin
        $error("decision row %0d col %0d with none pending",
               out_data.cell_row, out_data.cell_col);
        error_count++;
      end else begin
        want = decisions_due.pop_front();
        check_field("cell_row",   32'(want.cell_row),   32'(out_data.cell_row));
        check_field("cell_col",   32'(want.cell_col),   32'(out_data.cell_col));
        check_field("cell_value", 32'(want.cell_value), 32'(out_data.cell_value));
        check_field("is_minimum", 32'(want.is_minimum), 32'(out_data.is_minimum));
        check_field("risk_total", 32'(want.risk_total), 32'(out_data.risk_total));
        check_field("frame_last", 32'(want.frame_last), 32'(out_data.frame_last));
      end
      decisions_checked++;
      if (out_data.is_minimum === 1'b1) minima_seen++;
    end
  end

  // receiver: runs of free flow and stalls, plus one long hold while cells keep coming
  initial begin : result_sink
    int r, run;
    bit hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (!hold_done && cells_sent >= 200 && in_valid) begin
        hold_done = 1'b1;
        run = 300;
        out_stall <= 1'b1;
      end else if (r < 50) begin
        run = $urandom_range(1, 30);
        out_stall <= 1'b0;
      end else if (r < 90) begin
        run = $urandom_range(1, 3);
        out_stall <= 1'b1;
      end else begin
        run = $urandom_range(10, 40);
        out_stall <= 1'b1;
      end
      repeat (run) @(posedge clk);
    end
  end

  initial begin : watchdog
    #20000000;
    $display("tb: errors");
    $finish;
  end

  initial begin : stimulus
    script_row_t script[$];
    in_item_t it;
    int raw_w, raw_h, w, h, frames, len, style, phase, f, i;

    scan_col = 0;
    scan_row = 0;
    frame_risk = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // 2x2 frame from out-of-range writes (both clamp up to 2); a pad-marked cell
    // inside the frame counts as a cell, a pad-row item without the mark is a pad
    script = {script, mk_cfg(REG_IMAGE_WIDTH, CFG_BITS'(0))};
    script = {script, mk_cfg(REG_IMAGE_HEIGHT, CFG_BITS'(1))};
    script = {script, mk_cell(15, 1'b0)};
    script = {script, mk_cell(0, 1'b1)};
    script = {script, mk_expect(0, 1'b0, 0, 0, 15, 1'b0, 0, 1'b0)};
    script = {script, mk_expect(15, 1'b0, 0, 1, 0, 1'b1, 1, 1'b0)};
    script = {script, mk_expect(7, 1'b1, 1, 0, 0, 1'b1, 2, 1'b0)};
    script = {script, mk_expect(9, 1'b0, 1, 1, 15, 1'b0, 2, 1'b1)};
    // flat plateau: ties are never minima; frame cut short by a width write
    script = {script, mk_cfg(REG_IMAGE_WIDTH, CFG_BITS'(3))};
    script = {script, mk_cfg(REG_IMAGE_HEIGHT, CFG_BITS'(2))};
    for (i = 0; i < 5; i++) script = {script, mk_cell(5, 1'b0)};
    script = {script, mk_cfg(REG_IMAGE_WIDTH, CFG_BITS'(3))};
    // full 3x2 frame with corner and edge minima at the value extremes
    script = {script, mk_cell(0, 1'b0)};
    script = {script, mk_cell(15, 1'b0)};
    script = {script, mk_cell(0, 1'b0)};
    script = {script, mk_cell(15, 1'b0)};
    script = {script, mk_cell(0, 1'b0)};
    script = {script, mk_cell(15, 1'b0)};
    for (i = 0; i < 3; i++) script = {script, mk_cell(3, 1'b1)};

    foreach (script[k]) begin
      if (script[k].is_cfg) begin
        settle_block(4);
        write_reg(script[k].idx, script[k].val);
        settings_used++;
      end else begin
        offer_cell(script[k].pixel, script[k].typed, script[k].want);
      end
    end

    // random frames: mostly small geometries, one very wide and one very tall
    phase = 0;
    while (cells_sent < 800) begin
      if (phase == 2) begin
        raw_w = 255;
        raw_h = 0;
      end else if (phase == 5) begin
        raw_w = 1;
        raw_h = 128;
      end else begin
        raw_w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 9);
        raw_h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
      end
      settle_block(4);
      if ($urandom_range(0, 1)) begin
        write_reg(REG_IMAGE_WIDTH, CFG_BITS'(raw_w));
        write_reg(REG_IMAGE_HEIGHT, CFG_BITS'(raw_h));
      end else begin
        write_reg(REG_IMAGE_HEIGHT, CFG_BITS'(raw_h));
        write_reg(REG_IMAGE_WIDTH, CFG_BITS'(raw_w));
      end
      settings_used++;
      w = clamp_dim(raw_w, DEF_MAX_WIDTH);
      h = clamp_dim(raw_h, DEF_MAX_HEIGHT);
      gapless = ($urandom_range(0, 3) == 0);
      frames = (w * h > 100) ? 1 : $urandom_range(1, 3);
      for (f = 0; f < frames; f++) begin
        style = $urandom_range(0, 2);
        len = w * (h + 1);
        // now and then the last frame breaks off and the next write restarts it
        if (f == frames - 1 && $urandom_range(0, 4) == 0) len = $urandom_range(1, len - 1);
        for (i = 0; i < len; i++) begin
          // once, the sender waits mid-frame for every pending decision
          if (cells_sent == 400) settle_block(0);
          it.pad = (i < w * h) ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 9) != 0);
          it.cell_height = pick_height(style);
          offer_cell(it, 1'b0, '0);
        end
      end
      gapless = 1'b0;
      phase++;
    end

    settle_block(10);
    $display("summary: %0d cells over %0d geometry settings, %0d decisions checked, %0d minima",
             cells_sent, settings_used, decisions_checked, minima_seen);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/glmd_pkg.sv
rtl/glmd_cell.sv
rtl/glmd_line.sv
rtl/grid_local_minimum_detector_core.sv
tb/tb.sv
